/* src/i2a_pkg.sv */
// Shared types, constants and functions of the integer to ASCII converter.
package i2a_pkg;

   localparam int VAL_W   = 64;
   localparam int NDIG    = 20;
   localparam int DIG_W   = NDIG * 4;
   localparam int POS_W   = $clog2(NDIG + 1);
   localparam int CNT_W   = $clog2(VAL_W);
   localparam int QDEPTH  = 2;
   localparam int QPTR_W  = $clog2(QDEPTH);
   localparam int QCNT_W  = $clog2(QDEPTH + 1);

   localparam logic [6:0] CH_ZERO  = 7'h30;
   localparam logic [6:0] CH_A     = 7'h61;
   localparam logic [6:0] CH_X     = 7'h78;
   localparam logic [6:0] CH_MINUS = 7'h2d;

   localparam logic [2:0] OP_S32DEC = 3'd0;
   localparam logic [2:0] OP_U32DEC = 3'd1;
   localparam logic [2:0] OP_S64DEC = 3'd2;
   localparam logic [2:0] OP_U64DEC = 3'd3;
   localparam logic [2:0] OP_HEX64  = 3'd4;

   typedef struct packed {
      logic [VAL_W-1:0] mag;
      logic             hex;
      logic             neg;
   } i2a_job_type;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_CONV  = 7'b0000010,
      S_TRIM  = 7'b0000100,
      S_SIGN  = 7'b0001000,
      S_ZERO  = 7'b0010000,
      S_X     = 7'b0100000,
      S_DIGIT = 7'b1000000
   } back_state_type;

   function automatic logic [6:0] hex_char(input logic [3:0] nib);
      logic [6:0] c;
      if (nib < 4'd10) begin
         c = CH_ZERO + {3'b000, nib};
      end else begin
         c = CH_A + {3'b000, nib} - 7'd10;
      end
      return c;
   endfunction

endpackage

/* src/i2a_front.sv */
// Front part: classifies an accepted word into magnitude, base and sign.
module i2a_front
   import i2a_pkg::*;
(
   input  logic              req_push,
   input  logic              q_full,
   input  logic [2:0]        req_operation,
   input  logic [VAL_W-1:0]  req_value,
   output logic              job_valid,
   output i2a_job_type       job
);

   logic op_ok;
   logic [31:0] low32;

   assign low32 = req_value[31:0];

   always_comb begin
      op_ok   = 1'b1;
      job.mag = req_value;
      job.hex = 1'b0;
      job.neg = 1'b0;
      unique case (req_operation)
         OP_S32DEC: begin
            job.neg = low32[31];
            job.mag = {32'd0, (low32[31] ? (~low32 + 32'd1) : low32)};
         end
         OP_U32DEC: begin
            job.mag = {32'd0, low32};
         end
         OP_S64DEC: begin
            job.neg = req_value[VAL_W-1];
            job.mag = req_value[VAL_W-1] ? (~req_value + {{(VAL_W-1){1'b0}}, 1'b1})
                                         : req_value;
         end
         OP_U64DEC: begin
            job.mag = req_value;
         end
         OP_HEX64: begin
            job.hex = 1'b1;
         end
         default: begin
            op_ok = 1'b0;
         end
      endcase
   end

   // drop undefined operations
   assign job_valid = req_push & ~q_full & op_ok;

endmodule

/* src/i2a_queue.sv */
// Short job queue between the front and back parts.
module i2a_queue
   import i2a_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         wr_en,
   input  i2a_job_type  wr_job,
   output logic         full,
   input  logic         rd_en,
   output logic         rd_valid,
   output i2a_job_type  rd_job
);

   i2a_job_type       mem_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_wr, do_rd;

   assign full     = (count_ff == QCNT_W'(QDEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_job   = mem_ff[rd_ptr_ff];
   assign do_wr    = wr_en & ~full;
   assign do_rd    = rd_en & rd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (!do_wr && do_rd) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_job;
      end
   end

endmodule

/* src/i2a_back.sv */
// Back part: shift-add-3 decimal conversion, leading zero trim and character output.
module i2a_back
   import i2a_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         q_valid,
   input  i2a_job_type  q_job,
   output logic         q_pop,
   input  logic         rsp_pop,
   output logic         rsp_empty,
   output logic [6:0]   rsp_ch,
   output logic         rsp_last
);

   back_state_type    state_ff, state_in;
   logic [DIG_W-1:0]  dig_ff, dig_in;
   logic [VAL_W-1:0]  sh_ff, sh_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic              neg_ff, neg_in;
   logic              hex_ff, hex_in;
   logic              valid_ff, valid_in;
   logic [6:0]        ch_ff, ch_in;
   logic              last_ff, last_in;
   logic              emit_ok;
   logic [DIG_W-1:0]  adj;
   logic [3:0]        top_nib;

   assign emit_ok   = ~valid_ff | rsp_pop;
   assign rsp_empty = ~valid_ff;
   assign rsp_ch    = ch_ff;
   assign rsp_last  = last_ff;
   assign top_nib   = dig_ff[DIG_W-1 -: 4];
   assign q_pop     = (state_ff == S_IDLE) & q_valid;

   always_comb begin
      for (int i = 0; i < NDIG; i++) begin
         adj[i*4 +: 4] = (dig_ff[i*4 +: 4] >= 4'd5) ? dig_ff[i*4 +: 4] + 4'd3
                                                     : dig_ff[i*4 +: 4];
      end
   end

   always_comb begin
      state_in = state_ff;
      dig_in   = dig_ff;
      sh_in    = sh_ff;
      cnt_in   = cnt_ff;
      pos_in   = pos_ff;
      neg_in   = neg_ff;
      hex_in   = hex_ff;
      valid_in = valid_ff & ~rsp_pop;
      ch_in    = ch_ff;
      last_in  = last_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               neg_in = q_job.neg;
               hex_in = q_job.hex;
               pos_in = POS_W'(NDIG);
               cnt_in = '0;
               sh_in  = q_job.mag;
               if (q_job.hex) begin
                  dig_in   = {{(DIG_W-VAL_W){1'b0}}, q_job.mag};
                  state_in = S_TRIM;
               end else begin
                  dig_in   = '0;
                  state_in = S_CONV;
               end
            end
         end
         S_CONV: begin
            {dig_in, sh_in} = {adj[DIG_W-2:0], sh_ff, 1'b0};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(VAL_W - 1)) begin
               state_in = S_TRIM;
            end
         end
         S_TRIM: begin
            if (top_nib == 4'd0 && pos_ff > POS_W'(1)) begin
               dig_in = {dig_ff[DIG_W-5:0], 4'd0};
               pos_in = pos_ff - 1'b1;
            end else if (neg_ff) begin
               state_in = S_SIGN;
            end else if (hex_ff) begin
               state_in = S_ZERO;
            end else begin
               state_in = S_DIGIT;
            end
         end
         S_SIGN: begin
            if (emit_ok) begin
               valid_in = 1'b1;
               ch_in    = CH_MINUS;
               last_in  = 1'b0;
               state_in = S_DIGIT;
            end
         end
         S_ZERO: begin
            if (emit_ok) begin
               valid_in = 1'b1;
               ch_in    = CH_ZERO;
               last_in  = 1'b0;
               state_in = S_X;
            end
         end
         S_X: begin
            if (emit_ok) begin
               valid_in = 1'b1;
               ch_in    = CH_X;
               last_in  = 1'b0;
               state_in = S_DIGIT;
            end
         end
         S_DIGIT: begin
            if (emit_ok) begin
               valid_in = 1'b1;
               ch_in    = hex_char(top_nib);
               last_in  = (pos_ff == POS_W'(1));
               dig_in   = {dig_ff[DIG_W-5:0], 4'd0};
               pos_in   = pos_ff - 1'b1;
               if (pos_ff == POS_W'(1)) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dig_ff  <= dig_in;
      sh_ff   <= sh_in;
      cnt_ff  <= cnt_in;
      pos_ff  <= pos_in;
      neg_ff  <= neg_in;
      hex_ff  <= hex_in;
      ch_ff   <= ch_in;
      last_ff <= last_in;
   end

endmodule

/* src/int_to_ascii_digits.sv */
// Top level of the integer to ASCII converter.
// Usage:
//   Input queue: drive req_operation and req_value and raise req_push; the word
//   is taken on a clock edge with req_push high and req_full low. Operations
//   0..4 select signed/unsigned 32-bit decimal, signed/unsigned 64-bit decimal
//   and 64-bit hex with a 0x prefix; codes 5..7 are taken and produce nothing.
//   Result queue: while rsp_empty is low, rsp_ch holds the next character and
//   rsp_last marks the final character of a value; raise rsp_pop to take it.
//   Characters leave most significant first, one per cycle at most.
// Conversion:
//   Decimal words go through a one-bit-per-cycle shift-add-3 converter: the
//   back part loads the word, converts it, drops leading zero digits, then
//   sends a minus sign when the value is negative and then the digits. Hex
//   words skip the converter. Words pass through a two-entry job queue,
//   which lets new words be taken while the back part is busy.
// Reset clears both queues and the converter; no word is in flight after it.
// When the receiver stalls, the current character holds and the back part
// waits; req_full rises once the job queue fills.
module int_to_ascii_digits
   import i2a_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  logic [2:0]        req_operation,
   input  logic [VAL_W-1:0]  req_value,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic [6:0]        rsp_ch,
   output logic              rsp_last
);

   logic        job_valid;
   i2a_job_type job;
   logic        q_pop;
   logic        q_valid;
   i2a_job_type q_job;

   i2a_front u_front (
      .req_push      (req_push),
      .q_full        (req_full),
      .req_operation (req_operation),
      .req_value     (req_value),
      .job_valid     (job_valid),
      .job           (job)
   );

   i2a_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (job_valid),
      .wr_job   (job),
      .full     (req_full),
      .rd_en    (q_pop),
      .rd_valid (q_valid),
      .rd_job   (q_job)
   );

   i2a_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_job     (q_job),
      .q_pop     (q_pop),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_ch    (rsp_ch),
      .rsp_last  (rsp_last)
   );

endmodule

/* src/i2a_checker.sv */
// Port-level checks of the integer to ASCII converter and their binding.
module i2a_checker
   import i2a_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              rsp_empty,
   input  logic              rsp_pop,
   input  logic [6:0]        rsp_ch,
   input  logic              rsp_last
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_ch) && $stable(rsp_last)))
      else $error("waiting word changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> rsp_empty)
      else $error("result queue not empty after reset");

   a_char_set: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> ((rsp_ch >= CH_ZERO && rsp_ch <= CH_ZERO + 7'd9) ||
                      (rsp_ch >= CH_A && rsp_ch <= CH_A + 7'd5) ||
                      rsp_ch == CH_MINUS || rsp_ch == CH_X))
      else $error("character outside the output set");

   a_prefix_not_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && (rsp_ch == CH_MINUS || rsp_ch == CH_X)) |-> !rsp_last)
      else $error("prefix marked as final character");

endmodule

bind int_to_ascii_digits i2a_checker u_chk (.*);
